>>> design/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg: shared definitions for the positional PID controller
// Widths, register indexes and the configuration word type used by the
// register file, the datapath and the top level.
// ----------------------------------------------------------------------------
package ppc_pkg;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Sample and fixed-point format.
  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRACTION_BITS = 8;

  // Register and field widths.
  localparam int GAIN_W     = 16;
  localparam int BOUND_W    = 15;
  localparam int DRIVE_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Datapath widths, each just wide enough for its full range.
  localparam int ERR_W  = SAMPLE_WIDTH + 1;
  localparam int DIFF_W = SAMPLE_WIDTH + 2;
  localparam int P_W    = GAIN_W + ERR_W;
  localparam int D_W    = GAIN_W + DIFF_W;
  localparam int INT_W  = BOUND_W + FRACTION_BITS + 1;
  localparam int ISUM_W = imax(P_W, INT_W) + 1;
  localparam int SUM_W  = imax(D_W, imax(P_W, INT_W)) + 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INT_BOUND = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BOUND = CFG_IDX_W'(4);

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [BOUND_W-1:0]       integral_bound;
    logic [BOUND_W-1:0]       output_bound;
  } ppc_cfg_t;

endpackage

>>> design/ppc_cfg.sv
// ----------------------------------------------------------------------------
// ppc_cfg: configuration register file
// Holds the three gains and the two clamp bounds; writes to an unknown
// index are dropped.
// ----------------------------------------------------------------------------
module ppc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ppc_pkg::ppc_cfg_t               cfg
);
  import ppc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_P:    cfg.gain_p         <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_I:    cfg.gain_i         <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_D:    cfg.gain_d         <= $signed(cfg_data[GAIN_W-1:0]);
        REG_INT_BOUND: cfg.integral_bound <= cfg_data[BOUND_W-1:0];
        REG_OUT_BOUND: cfg.output_bound   <= cfg_data[BOUND_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/ppc_calc.sv
// ----------------------------------------------------------------------------
// ppc_calc: PID arithmetic for one sample
// Forms the three terms, updates and clamps the integral, clamps the sum
// and floors it at zero to give the integer drive.
// ----------------------------------------------------------------------------
module ppc_calc (
  input  ppc_pkg::ppc_cfg_t                      cfg,
  input  logic signed [ppc_pkg::ERR_W-1:0]       err,
  input  logic signed [ppc_pkg::ERR_W-1:0]       prev_err,
  input  logic signed [ppc_pkg::INT_W-1:0]       integral,
  output logic signed [ppc_pkg::INT_W-1:0]       integral_next,
  output logic [ppc_pkg::DRIVE_W-1:0]            drive_next
);
  import ppc_pkg::*;

  logic signed [DIFF_W-1:0] diff;
  logic signed [P_W-1:0]    p_term;
  logic signed [P_W-1:0]    i_prod;
  logic signed [D_W-1:0]    d_term;
  logic signed [ISUM_W-1:0] isum;
  logic signed [ISUM_W-1:0] ilim;
  logic signed [ISUM_W-1:0] iclamp;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  olim;
  logic signed [SUM_W-1:0]  sclamp;

  always_comb begin
    diff   = DIFF_W'(err) - DIFF_W'(prev_err);
    p_term = P_W'($signed(cfg.gain_p)) * P_W'(err);
    i_prod = P_W'($signed(cfg.gain_i)) * P_W'(err);
    d_term = D_W'($signed(cfg.gain_d)) * D_W'(diff);

    // The integral is clamped after accumulation, every sample.
    isum = ISUM_W'(integral) + ISUM_W'(i_prod);
    ilim = ISUM_W'(cfg.integral_bound) << FRACTION_BITS;
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end
    integral_next = INT_W'(iclamp);

    sum  = SUM_W'(p_term) + SUM_W'(integral_next) + SUM_W'(d_term);
    olim = SUM_W'(cfg.output_bound) << FRACTION_BITS;
    if (sum > olim) begin
      sclamp = olim;
    end else if (sum < -olim) begin
      sclamp = -olim;
    end else begin
      sclamp = sum;
    end

    if (sclamp <= 0) begin
      drive_next = '0;
    end else begin
      drive_next = sclamp[FRACTION_BITS +: DRIVE_W];
    end
  end

endmodule

>>> design/positional_pid_clamped_top.sv
// ----------------------------------------------------------------------------
// positional_pid_clamped_top: positional PID controller with anti-windup
// Clamped integral, clamped and zero-floored output, fixed-point gains.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the output side is not
// stalled and returns one drive word for each, through the error register
// and then the result register. A single arithmetic pass lies between
// those two registers: the three gain multipliers work in parallel, and
// the integral and the last error are updated in the same cycle that the
// result is registered, so the next sample sees them at once. Gains are
// signed Q8.8; the integral is held with eight fraction bits and clamped to
// plus or minus integral_bound after each accumulation; the sum of the terms
// is clamped to plus or minus output_bound, floored at zero and truncated to
// an integer. Reset clears the gains, the bounds, the integral and the last
// error. Configuration should be written only while no word is in flight.
// ----------------------------------------------------------------------------
module positional_pid_clamped_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [ppc_pkg::SAMPLE_WIDTH-1:0] measured,
  input  logic signed [ppc_pkg::SAMPLE_WIDTH-1:0] target,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ppc_pkg::DRIVE_W-1:0]           drive,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import ppc_pkg::*;

  ppc_cfg_t cfg;

  // Input stage: the error of the accepted word.
  logic                    err_valid;
  logic signed [ERR_W-1:0] err;

  // Controller state, advanced once per word.
  logic signed [INT_W-1:0] integral_acc;
  logic signed [ERR_W-1:0] previous_error;

  logic signed [INT_W-1:0] integral_next;
  logic [DRIVE_W-1:0]      drive_next;

  logic in_accept;
  logic advance;

  // The error stage moves on whenever the result register is empty or its
  // word is being taken this cycle; the input side stalls only when the
  // error stage is full and cannot move.
  assign advance   = err_valid && (!out_valid || !out_stall);
  assign in_stall  = err_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  ppc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppc_calc u_calc (
    .cfg           (cfg),
    .err           (err),
    .prev_err      (previous_error),
    .integral      (integral_acc),
    .integral_next (integral_next),
    .drive_next    (drive_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      err_valid      <= 1'b0;
      out_valid      <= 1'b0;
      integral_acc   <= '0;
      previous_error <= '0;
    end else begin
      err_valid <= in_accept || (err_valid && !advance);
      out_valid <= advance || (out_valid && out_stall);
      if (advance) begin
        integral_acc   <= integral_next;
        previous_error <= err;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      err <= ERR_W'(target) - ERR_W'(measured);
    end
    if (advance) begin
      drive <= drive_next;
    end
  end

`ifndef ASSERT_OFF
  // A stall toward the source means a word is waiting in the error stage.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> err_valid)
    else $error("input stalled with an empty error stage");

  // A word in the error stage is never dropped while it cannot move.
  a_err_held: assert property (@(posedge clk) disable iff (rst)
    err_valid && !advance |=> err_valid)
    else $error("error stage word lost");

  // Controller state changes only when a word passes to the result register.
  a_state_steady: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(integral_acc) && $stable(previous_error))
    else $error("controller state changed without a word");

  // A presented drive never exceeds the output bound.
  a_drive_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive <= cfg.output_bound)
    else $error("drive above output bound");
`endif

endmodule
